/* hw/rtl/u8s_pkg.sv */
// shared types and byte-class constants for the utf-8 byte sanitizer
package u8s_pkg;

  // byte constants
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MIN   = 8'h80;
  localparam logic [7:0] CONT_MAX   = 8'hBF;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD3_OVL  = 8'hE0;
  localparam logic [7:0] OVL_MIN    = 8'hA0;
  localparam logic [7:0] LEAD3_SUR  = 8'hED;
  localparam logic [7:0] SUR_MAX    = 8'h9F;
  localparam logic [7:0] SPACE_BYTE = 8'h20;

  // most bytes one input transaction can release
  localparam int unsigned MAX_RES = 3;

  // decode result for one input byte
  typedef struct packed {
    logic [1:0]      num;       // bytes released, 0..3
    logic [2:0][7:0] data;      // released bytes, slot 0 first
    logic [1:0]      cnt_nxt;   // held byte count after this byte
    logic            hold0;     // capture input byte as held lead
    logic            hold1;     // capture input byte as held continuation
  } u8s_dec_t;

  // one queued result transaction
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } u8s_ent_t;

endpackage

/* hw/rtl/u8s_decode.sv */
// combinational sequence decoder: judges one byte against the held bytes
module u8s_decode (
  input  logic [7:0]        cur_byte,
  input  logic              cur_last,
  input  logic [1:0]        pend_cnt,
  input  logic [7:0]        pend0,
  input  logic [7:0]        pend1,
  output u8s_pkg::u8s_dec_t dec
);
  import u8s_pkg::*;

  logic       cur_cont;
  logic       p0_lead2;
  logic       tri_ok;
  logic       fr_hold;
  logic [7:0] fr_byte;

  // byte classes
  assign cur_cont = (cur_byte >= CONT_MIN) && (cur_byte <= CONT_MAX);
  assign p0_lead2 = (pend0 >= LEAD2_MIN) && (pend0 <= LEAD2_MAX);
  assign tri_ok   = !((pend0 == LEAD3_OVL) && (pend1 < OVL_MIN)) &&
                    !((pend0 == LEAD3_SUR) && (pend1 > SUR_MAX));

  // judging the byte as a fresh one
  assign fr_hold = (((cur_byte >= LEAD2_MIN) && (cur_byte <= LEAD2_MAX)) ||
                    ((cur_byte >= LEAD3_MIN) && (cur_byte <= LEAD3_MAX))) && !cur_last;
  assign fr_byte = (cur_byte <= ASCII_MAX) ? cur_byte : SPACE_BYTE;

  // release and hold decisions
  always_comb begin
    dec = '0;
    unique case (pend_cnt)
      2'd0: begin
        dec.data[0] = fr_byte;
        dec.num     = fr_hold ? 2'd0 : 2'd1;
        dec.hold0   = fr_hold;
        dec.cnt_nxt = fr_hold ? 2'd1 : 2'd0;
      end
      2'd1: begin
        if (cur_cont) begin
          if (p0_lead2) begin
            dec.data[0] = pend0;
            dec.data[1] = cur_byte;
            dec.num     = 2'd2;
          end else if (cur_last) begin
            dec.data[0] = SPACE_BYTE;
            dec.data[1] = SPACE_BYTE;
            dec.num     = 2'd2;
          end else begin
            dec.hold1   = 1'b1;
            dec.cnt_nxt = 2'd2;
          end
        end else begin
          // broken sequence, byte judged fresh after the space
          dec.data[0] = SPACE_BYTE;
          dec.data[1] = fr_byte;
          dec.num     = fr_hold ? 2'd1 : 2'd2;
          dec.hold0   = fr_hold;
          dec.cnt_nxt = fr_hold ? 2'd1 : 2'd0;
        end
      end
      default: begin
        if (cur_cont) begin
          if (tri_ok) begin
            dec.data[0] = pend0;
            dec.data[1] = pend1;
            dec.data[2] = cur_byte;
            dec.num     = 2'd3;
          end else begin
            // rejected triple: lead dropped, continuations become spaces
            dec.data[0] = SPACE_BYTE;
            dec.data[1] = SPACE_BYTE;
            dec.num     = 2'd2;
          end
        end else begin
          dec.data[0] = SPACE_BYTE;
          dec.data[1] = SPACE_BYTE;
          dec.data[2] = fr_byte;
          dec.num     = fr_hold ? 2'd2 : 2'd3;
          dec.hold0   = fr_hold;
          dec.cnt_nxt = fr_hold ? 2'd1 : 2'd0;
        end
      end
    endcase
  end

endmodule

/* hw/rtl/utf8_byte_sanitizer.sv */
// utf-8 byte sanitizer top level: decoder, held-byte state and result queue
// release: an input transaction's released bytes enter the result queue at its
//   accepting edge; bytes of an open sequence wait for the byte that closes it
// throughput: one input byte per cycle unless in_stall, raised when the result queue
//   has fewer than three free entries; one output byte per cycle unless out_stall
// reset (rst_n low, synchronous): held-byte count and queue pointers clear, queue empty
module utf8_byte_sanitizer #(
  parameter int unsigned FIFO_DEPTH = 8   // power of two, at least 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import u8s_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [1:0]       pend_cnt_r;
  logic [1:0]       pend_cnt_nxt;
  logic [7:0]       pend0_r;
  logic [7:0]       pend1_r;
  u8s_dec_t         dec;
  u8s_ent_t         queue_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] q_cnt_r;
  logic [CNT_W-1:0] q_cnt_nxt;
  logic             in_acc;
  logic             out_acc;
  logic [1:0]       push_n;

  // sequence decode
  u8s_decode u_decode (
    .cur_byte (in_byte),
    .cur_last (in_last),
    .pend_cnt (pend_cnt_r),
    .pend0    (pend0_r),
    .pend1    (pend1_r),
    .dec      (dec)
  );

  // handshakes
  assign in_stall  = q_cnt_r > CNT_W'(FIFO_DEPTH - MAX_RES);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = q_cnt_r != '0;
  assign out_acc   = out_valid && !out_stall;
  assign push_n    = in_acc ? dec.num : 2'd0;

  // next held count, last byte of a text clears it
  assign pend_cnt_nxt = in_last ? 2'd0 : dec.cnt_nxt;

  // queue occupancy
  assign q_cnt_nxt = q_cnt_r + CNT_W'(push_n) - CNT_W'(out_acc);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r <= 2'd0;
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      q_cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        pend_cnt_r <= pend_cnt_nxt;
        wr_ptr_r   <= wr_ptr_r + PTR_W'(push_n);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // held bytes
  always_ff @(posedge clk) begin
    if (in_acc && dec.hold0) begin
      pend0_r <= in_byte;
    end
    if (in_acc && dec.hold1) begin
      pend1_r <= in_byte;
    end
  end

  // queue writes, up to three entries per transaction
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (in_acc && (2'(i) < dec.num)) begin
        queue_r[wr_ptr_r + PTR_W'(i)] <= '{data: dec.data[i],
                                           last: in_last && (2'(i + 1) == dec.num)};
      end
    end
  end

  // queue head
  assign out_byte = queue_r[rd_ptr_r].data;
  assign out_last = queue_r[rd_ptr_r].last;

endmodule
